### rtl/core/char_class_range_table_assert.svh
// assertion macros for the character class range table
`ifndef CHAR_CLASS_RANGE_TABLE_ASSERT_SVH
`define CHAR_CLASS_RANGE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define CCRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("char_class_range_table: check failed");
`define CCRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("char_class_range_table: check failed");
`else
`define CCRT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CCRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/ccrt_pkg.sv
package ccrt_pkg;

  localparam int MAX_RANGES = 32;
  localparam int CODE_LIMIT = 1114112;
  localparam int CODE_W     = 21;
  localparam int CNT_W      = $clog2(MAX_RANGES + 2);
  localparam int OUT_CNT_W  = 6;
  localparam int ACT_W      = 2;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam code_t LIMIT = CODE_W'(CODE_LIMIT);

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD  = 2'd0,
    ACT_TEST = 2'd1,
    ACT_COMP = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLASSIFY,
    CELL_INSERT,
    CELL_HEAD,
    CELL_MERGE,
    CELL_COMP
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_MERGE
  } state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e op;
    code_t    lo_new;
    code_t    hi_new;
    code_t    cp;
    logic     skip_first;
  } cell_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    code_t lo;
    code_t hi;
    logic  valid;
    logic  below;
    logic  absorb;
  } cell_link_t;

  // per-cell status toward the controller
  typedef struct packed {
    logic hit;
    logic merge;
    logic at_limit;
  } cell_stat_t;

endpackage

### rtl/core/ccrt_cell.sv
module ccrt_cell import ccrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cmd_t  cmd_i,
  input  logic       valid_i,
  input  cell_link_t left_i,
  input  cell_link_t right_i,
  output cell_link_t link_o,
  output cell_stat_t stat_o
);

  code_t lo_q, lo_d, hi_q, hi_d;
  logic  below_q, below_d, absorb_q, absorb_d, hit_q, hit_d;
  logic  head, after;

  // first cell that overlaps or touches the added range
  assign head  = absorb_q & ~left_i.absorb;
  assign after = ~below_q & ~head;

  assign link_o = '{lo: lo_q, hi: hi_q, valid: valid_i, below: below_q, absorb: absorb_q};

  assign stat_o.hit      = hit_q;
  assign stat_o.merge    = head & right_i.valid & (right_i.lo <= hi_q);
  assign stat_o.at_limit = valid_i & (hi_q == LIMIT);

  always_comb begin
    lo_d     = lo_q;
    hi_d     = hi_q;
    below_d  = below_q;
    absorb_d = absorb_q;
    hit_d    = hit_q;
    unique case (cmd_i.op)
      CELL_CLASSIFY: begin
        below_d  = valid_i & (hi_q < cmd_i.lo_new);
        absorb_d = valid_i & ~(hi_q < cmd_i.lo_new) & (lo_q <= cmd_i.hi_new);
        hit_d    = valid_i & (lo_q <= cmd_i.cp) & (cmd_i.cp < hi_q);
      end
      CELL_INSERT: begin
        if (!below_q) begin
          if (left_i.below) begin
            lo_d = cmd_i.lo_new;
            hi_d = cmd_i.hi_new;
          end else begin
            lo_d = left_i.lo;
            hi_d = left_i.hi;
          end
        end
      end
      CELL_HEAD: begin
        if (head) begin
          lo_d = (cmd_i.lo_new < lo_q) ? cmd_i.lo_new : lo_q;
          hi_d = (cmd_i.hi_new > hi_q) ? cmd_i.hi_new : hi_q;
        end
      end
      CELL_MERGE: begin
        if (head) begin
          hi_d = (right_i.hi > hi_q) ? right_i.hi : hi_q;
        end else if (after) begin
          lo_d = right_i.lo;
          hi_d = right_i.hi;
        end
      end
      CELL_COMP: begin
        if (cmd_i.skip_first) begin
          lo_d = hi_q;
          hi_d = right_i.valid ? right_i.lo : LIMIT;
        end else begin
          lo_d = left_i.hi;
          hi_d = valid_i ? lo_q : LIMIT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      below_q  <= 1'b0;
      absorb_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      below_q  <= below_d;
      absorb_q <= absorb_d;
      hit_q    <= hit_d;
    end
  end

endmodule

### rtl/core/char_class_range_table.sv
// steps: on the accepting edge every cell classifies itself; the apply step then
//   registers the result strobe for test, insert, complement and refused items; an
//   add that touches held ranges widens the head there, then merges in ST_MERGE, walking
//   the row one absorbed range per cycle; busy holds off a new item until the result strobe
// reset: asynchronous active low, empties the class; range storage itself is not cleared
// the receiver cannot stall: each result strobe lasts exactly one cycle
`include "char_class_range_table_assert.svh"

module char_class_range_table import ccrt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [ACT_W-1:0]     action_i,
  input  logic [CODE_W-1:0]    range_start_i,
  input  logic [CODE_W-1:0]    range_end_i,
  input  logic [CODE_W-1:0]    codepoint_i,
  output logic                 result_valid_o,
  output logic                 is_member_o,
  output logic [OUT_CNT_W-1:0] range_count_o,
  output logic                 table_full_o
);

  localparam cell_link_t EDGE_LEFT  = '{lo: '0, hi: '0, valid: 1'b1, below: 1'b1, absorb: 1'b0};
  localparam cell_link_t EDGE_RIGHT = '0;

  state_e    state_q, state_d;
  cnt_t      n_q, n_d;
  action_e   action_q;
  code_t     s_q, e_q, cp_q;
  logic      empty_q;
  logic      done_q, done_d, member_q, member_d, full_q, full_d;

  code_t     s_clamp, e_clamp;
  cell_cmd_t cmd;

  cell_link_t link   [MAX_RANGES];
  cell_link_t left_w [MAX_RANGES];
  cell_link_t right_w[MAX_RANGES];
  cell_stat_t stat   [MAX_RANGES];
  logic [MAX_RANGES-1:0] valid_v, abs_v, hit_v, merge_v, limit_v;

  logic any_abs, any_hit, any_merge, any_limit, first_at_zero;
  logic accept;

  assign accept = start & ~busy;
  assign busy   = (state_q != ST_IDLE);

  // bounds above the code limit are pulled back onto it
  assign s_clamp = (range_start_i > LIMIT) ? LIMIT : range_start_i;
  assign e_clamp = (range_end_i > LIMIT) ? LIMIT : range_end_i;

  // the row of cells, each holding one range and talking to its neighbors
  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    assign valid_v[g] = (CNT_W'(g) < n_q);

    if (g == 0) begin : g_left_edge
      assign left_w[g] = EDGE_LEFT;
    end else begin : g_left
      assign left_w[g] = link[g-1];
    end

    if (g == MAX_RANGES - 1) begin : g_right_edge
      assign right_w[g] = EDGE_RIGHT;
    end else begin : g_right
      assign right_w[g] = link[g+1];
    end

    ccrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .valid_i (valid_v[g]),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .link_o  (link[g]),
      .stat_o  (stat[g])
    );

    assign abs_v[g]   = link[g].absorb;
    assign hit_v[g]   = stat[g].hit;
    assign merge_v[g] = stat[g].merge;
    assign limit_v[g] = stat[g].at_limit;
  end

  assign any_abs   = |abs_v;
  assign any_hit   = |hit_v;
  assign any_merge = |merge_v;
  assign any_limit = |limit_v;

  // complement drops the leading gap when the class already starts at zero
  assign first_at_zero = link[0].valid & (link[0].lo == '0);

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    done_d   = 1'b0;
    member_d = member_q;
    full_d   = full_q;

    cmd.op         = CELL_HOLD;
    cmd.lo_new     = s_q;
    cmd.hi_new     = e_q;
    cmd.cp         = cp_q;
    cmd.skip_first = first_at_zero;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // every cell classifies itself against the new transaction
          cmd.op     = CELL_CLASSIFY;
          cmd.lo_new = s_clamp;
          cmd.hi_new = e_clamp;
          cmd.cp     = codepoint_i;
          state_d    = ST_APPLY;
        end
      end

      ST_APPLY: begin
        done_d   = 1'b1;
        member_d = 1'b0;
        full_d   = 1'b0;
        state_d  = ST_IDLE;
        case (action_q)
          ACT_ADD: begin
            if (!empty_q) begin
              if (any_abs) begin
                // widen the first overlapping range, then fold neighbors in
                cmd.op  = CELL_HEAD;
                done_d  = 1'b0;
                state_d = ST_MERGE;
              end else if (n_q >= CNT_W'(MAX_RANGES)) begin
                full_d = 1'b1;
              end else begin
                cmd.op = CELL_INSERT;
                n_d    = n_q + CNT_W'(1);
              end
            end
          end
          ACT_TEST: begin
            member_d = any_hit;
          end
          ACT_COMP: begin
            // gap count is n + 1, minus a leading and a trailing gap that vanish
            if ((n_q == CNT_W'(MAX_RANGES)) && !first_at_zero && !any_limit) begin
              full_d = 1'b1;
            end else begin
              cmd.op = CELL_COMP;
              n_d    = n_q + CNT_W'(1) - CNT_W'(first_at_zero) - CNT_W'(any_limit);
            end
          end
          default: begin
          end
        endcase
      end

      ST_MERGE: begin
        if (any_merge) begin
          // head absorbs its right neighbor, the tail slides left by one
          cmd.op = CELL_MERGE;
          n_d    = n_q - CNT_W'(1);
        end else begin
          done_d   = 1'b1;
          member_d = 1'b0;
          full_d   = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // transaction fields held for the apply and merge steps
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_e'(action_i);
      s_q      <= s_clamp;
      e_q      <= e_clamp;
      cp_q     <= codepoint_i;
      empty_q  <= (s_clamp >= e_clamp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      n_q      <= '0;
      done_q   <= 1'b0;
      member_q <= 1'b0;
      full_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      done_q   <= done_d;
      member_q <= member_d;
      full_q   <= full_d;
    end
  end

  assign result_valid_o = done_q;
  assign is_member_o    = member_q;
  assign table_full_o   = full_q;
  assign range_count_o  = OUT_CNT_W'(n_q);

  // the class never holds more ranges than the row has cells
  `CCRT_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, n_q <= CNT_W'(MAX_RANGES))
  // a strobe never lasts more than one cycle
  `CCRT_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o)
  // a refused transaction leaves the range count alone
  `CCRT_ASSERT_IMPL(a_refuse_keeps, clk_i, rst_ni, result_valid_o && table_full_o, $stable(n_q))
  // merging only happens with a head range in place
  `CCRT_ASSERT_IMPL(a_merge_nonempty, clk_i, rst_ni, state_q == ST_MERGE, n_q != '0)

endmodule
